### rtl/core/ewsm_pkg.sv
// ----------------------------------------------------------------------------
// ewsm_pkg
// Codes, types and constants shared by the E2E window state machine files.
// ----------------------------------------------------------------------------
package ewsm_pkg;

	localparam logic [7:0] MAX_WINDOW = 8'd255;

	// state codes
	localparam logic [2:0] ST_NODATA  = 3'd0;
	localparam logic [2:0] ST_INIT    = 3'd1;
	localparam logic [2:0] ST_VALID   = 3'd2;
	localparam logic [2:0] ST_SYNC    = 3'd3;
	localparam logic [2:0] ST_INVALID = 3'd4;

	// profile check status codes
	localparam logic [2:0] CS_OK       = 3'd0;
	localparam logic [2:0] CS_REPEATED = 3'd1;
	localparam logic [2:0] CS_WRONGSEQ = 3'd2;
	localparam logic [2:0] CS_ERROR    = 3'd3;

	// item kinds
	localparam logic KIND_CHECK = 1'b0;
	localparam logic KIND_RESET = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERROR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_OK      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_THR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd4;

	typedef struct packed {
		logic [7:0]  window_size;
		logic [7:0]  max_error_threshold;
		logic [7:0]  min_ok_threshold;
		logic [15:0] sync_threshold;
		logic [31:0] timeout_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  fsm_state;
		logic [7:0]  ok_count;
		logic [7:0]  err_count;
		logic [15:0] sync_count;
		logic [31:0] last_ok_time;
		logic        avail_flag;
	} sm_t;

	typedef struct packed {
		logic [2:0] sm_state;
		logic       data_valid;
		logic       data_available;
		logic [7:0] error_count;
		logic [7:0] window_fill;
	} res_t;

endpackage

### rtl/core/ewsm_if.sv
// ----------------------------------------------------------------------------
// ewsm_if
// Valid/ready channels: check items, results and configuration writes.
// ----------------------------------------------------------------------------
interface ewsm_chk_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [2:0]  check_status;
	logic [31:0] time_stamp;

	modport source (output valid, kind, check_status, time_stamp, input ready);
	modport sink   (input valid, kind, check_status, time_stamp, output ready);
endinterface

interface ewsm_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] sm_state;
	logic       data_valid;
	logic       data_available;
	logic [7:0] error_count;
	logic [7:0] window_fill;

	modport source (output valid, sm_state, data_valid, data_available, error_count,
		window_fill, input ready);
	modport sink   (input valid, sm_state, data_valid, data_available, error_count,
		window_fill, output ready);
endinterface

interface ewsm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/ewsm_step.sv
// ----------------------------------------------------------------------------
// ewsm_step
// Next-state and result logic for one item: counter update, timeout test,
// state transition, and the clear done by a reset item.
// ----------------------------------------------------------------------------
module ewsm_step
	import ewsm_pkg::*;
(
	input  cfg_t        cfg,
	input  sm_t         cur,
	input  logic        kind,
	input  logic [2:0]  check_status,
	input  logic [31:0] time_stamp,
	output sm_t         nxt,
	output res_t        res
);

	logic        is_ok;
	logic        is_err;
	logic [7:0]  win;
	logic [7:0]  ok_inc;
	logic [7:0]  err_inc;
	logic [7:0]  ok_cap;
	logic [7:0]  err_cap;
	logic [15:0] sync_inc;
	logic [31:0] elapsed;
	logic        timed_out;
	logic        err_hit;
	logic        ok_met;
	logic [2:0]  st_new;
	logic [8:0]  sum;

	assign is_ok  = (check_status == CS_OK);
	assign is_err = (check_status == CS_ERROR);
	assign win    = (cfg.window_size < MAX_WINDOW) ? cfg.window_size : MAX_WINDOW;

	always_comb begin
		if (is_ok) begin
			ok_inc   = (cur.ok_count != 8'hFF) ? cur.ok_count + 8'd1 : cur.ok_count;
			err_inc  = (cur.err_count != 8'd0) ? cur.err_count - 8'd1 : cur.err_count;
			sync_inc = (cur.sync_count != 16'hFFFF) ? cur.sync_count + 16'd1 : cur.sync_count;
		end else begin
			ok_inc   = (cur.ok_count != 8'd0) ? cur.ok_count - 8'd1 : cur.ok_count;
			err_inc  = (cur.err_count != 8'hFF) ? cur.err_count + 8'd1 : cur.err_count;
			sync_inc = cur.sync_count;
		end
	end

	assign ok_cap  = (ok_inc > win) ? win : ok_inc;
	assign err_cap = (err_inc > win) ? win : err_inc;

	assign elapsed   = time_stamp - cur.last_ok_time;
	assign timed_out = (cfg.timeout_limit != 32'd0) && (cur.last_ok_time != 32'd0)
		&& (elapsed > cfg.timeout_limit);

	// thresholds compare against the counters after this item's update
	assign err_hit = (err_cap >= cfg.max_error_threshold);
	assign ok_met  = (ok_cap >= cfg.min_ok_threshold);

	always_comb begin
		case (cur.fsm_state)
			ST_NODATA: begin
				if (is_ok)       st_new = ST_INIT;
				else if (is_err) st_new = ST_INVALID;
				else             st_new = ST_NODATA;
			end
			ST_INIT: begin
				if (is_ok)       st_new = ok_met ? ST_VALID : ST_INIT;
				else if (is_err) st_new = err_hit ? ST_INVALID : ST_INIT;
				else             st_new = ST_INIT;
			end
			ST_VALID: begin
				if (is_err)      st_new = err_hit ? ST_INVALID : ST_SYNC;
				else if (check_status == CS_REPEATED || check_status == CS_WRONGSEQ)
					st_new = ST_SYNC;
				else             st_new = ST_VALID;
			end
			ST_SYNC: begin
				if (is_ok)
					st_new = (sync_inc >= cfg.sync_threshold) ? ST_VALID : ST_SYNC;
				else if (is_err) st_new = err_hit ? ST_INVALID : ST_SYNC;
				else             st_new = ST_SYNC;
			end
			ST_INVALID: begin
				if (is_ok)       st_new = ok_met ? ST_VALID : ST_SYNC;
				else             st_new = ST_INVALID;
			end
			default: st_new = ST_INVALID;
		endcase
	end

	always_comb begin
		if (kind == KIND_RESET) begin
			nxt = '0;
			nxt.fsm_state = ST_NODATA;
		end else begin
			nxt.ok_count   = ok_cap;
			nxt.err_count  = err_cap;
			nxt.sync_count = sync_inc;
			if (timed_out) begin
				// skip the transition table, keep the last valid time
				nxt.fsm_state    = ST_INVALID;
				nxt.last_ok_time = cur.last_ok_time;
				nxt.avail_flag   = 1'b0;
			end else begin
				nxt.fsm_state    = st_new;
				nxt.last_ok_time = is_ok ? time_stamp : cur.last_ok_time;
				nxt.avail_flag   = (st_new == ST_VALID) || (st_new == ST_SYNC)
					|| (st_new == ST_INIT);
			end
		end
	end

	assign sum = {1'b0, nxt.ok_count} + {1'b0, nxt.err_count};

	always_comb begin
		res.sm_state       = nxt.fsm_state;
		res.data_valid     = (nxt.fsm_state == ST_VALID);
		res.data_available = nxt.avail_flag;
		res.error_count    = nxt.err_count;
		res.window_fill    = (sum > {1'b0, win}) ? win : sum[7:0];
	end

endmodule

### rtl/core/e2e_window_state_machine.sv
// ----------------------------------------------------------------------------
// e2e_window_state_machine
// E2E protection state machine with capped ok/error window counters.
// Path: an accepted item is held in the input register, then the result
// register loads its result once the result side can take a new one.
// Throughput: one item per cycle while results are taken; the state registers
// update when the input register hands its item to the result register.
// Reset: arst_n clears the machine to NODATA and loads register defaults.
// ----------------------------------------------------------------------------
module e2e_window_state_machine
	import ewsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ewsm_chk_if.sink    chk,
	ewsm_res_if.source  res,
	ewsm_cfg_if.sink    cfg
);

	cfg_t        cfg_q;
	sm_t         st_q;
	sm_t         st_nxt;
	res_t        res_nxt;
	res_t        res_q;
	logic        valid_s1;
	logic        kind_s1;
	logic [2:0]  status_s1;
	logic [31:0] stamp_s1;
	logic        res_valid_q;
	logic        adv_s1;
	logic        chk_acc;

	assign adv_s1    = valid_s1 && (!res_valid_q || res.ready);
	assign chk.ready = !valid_s1 || adv_s1;
	assign chk_acc   = chk.valid && chk.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size         <= 8'd8;
			cfg_q.max_error_threshold <= 8'd3;
			cfg_q.min_ok_threshold    <= 8'd3;
			cfg_q.sync_threshold      <= 16'd3;
			cfg_q.timeout_limit       <= 32'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WINDOW_SIZE: cfg_q.window_size         <= cfg.data[7:0];
				REG_MAX_ERROR:   cfg_q.max_error_threshold <= cfg.data[7:0];
				REG_MIN_OK:      cfg_q.min_ok_threshold    <= cfg.data[7:0];
				REG_SYNC_THR:    cfg_q.sync_threshold      <= cfg.data[15:0];
				REG_TIMEOUT:     cfg_q.timeout_limit       <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chk_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chk_acc) begin
			kind_s1   <= chk.kind;
			status_s1 <= chk.check_status;
			stamp_s1  <= chk.time_stamp;
		end
	end

	ewsm_step u_step (
		.cfg          (cfg_q),
		.cur          (st_q),
		.kind         (kind_s1),
		.check_status (status_s1),
		.time_stamp   (stamp_s1),
		.nxt          (st_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= '0;
			st_q.fsm_state <= ST_NODATA;
		end else if (adv_s1) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.sm_state       = res_q.sm_state;
	assign res.data_valid     = res_q.data_valid;
	assign res.data_available = res_q.data_available;
	assign res.error_count    = res_q.error_count;
	assign res.window_fill    = res_q.window_fill;

	// availability always follows the state, the timeout path into INVALID included
	a_avail_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.avail_flag == ((st_q.fsm_state == ST_VALID) || (st_q.fsm_state == ST_SYNC)
			|| (st_q.fsm_state == ST_INIT)))
		else $error("avail flag out of step with state");

	a_reset_item_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (kind_s1 == KIND_RESET) |=> (st_q.fsm_state == ST_NODATA)
			&& (st_q.ok_count == 8'd0) && (st_q.err_count == 8'd0)
			&& (st_q.last_ok_time == 32'd0))
		else $error("reset item left state behind");

	// a blocked result must freeze the machine
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |=> $stable(st_q))
		else $error("state moved while result stalled");

endmodule
